// File: rtl/stft_pkg.sv
// ----------------------------------------------------------------------------
// stft_pkg
// Shared widths, register map and constants of the face tensor row unit.
// ----------------------------------------------------------------------------
package stft_pkg;

	localparam int IN_W      = 20;           // corner gradient component
	localparam int N_W       = IN_W + 2;     // sum of four corners
	localparam int SQ_W      = 2 * N_W;      // sum of three squares
	localparam int MAG_W     = N_W;          // floor(sqrt) of the sum of squares
	localparam int SQ_STEPS  = MAG_W;        // one result bit per root stage
	localparam int Q_W       = MAG_W + 2;    // quotient bits
	localparam int DIV_STEPS = Q_W;          // one quotient bit per divide stage
	localparam int DV_W      = SQ_W + 2;     // divide compare width
	localparam int OUT_W     = 24;
	localparam int V_W       = OUT_W + 3;    // row entry before saturation
	localparam int DG_W      = MAG_W + 1;    // diagonal term

	// floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT for x below 2^24
	localparam int RECIP_W      = 24;
	localparam int RECIP3_SHIFT = 25;
	localparam logic [RECIP_W-1:0] RECIP3 = 24'hAAAAAB;
	localparam int DP_W = DG_W + RECIP_W;

	localparam int LATENCY = 3 + SQ_STEPS + 2 + DIV_STEPS + 1;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FACE_AXIS   = 2'd0,
		REG_FACTOR_MODE = 2'd1,
		REG_MIN_MAG     = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FACTOR_ONE   = 2'd0,
		FACTOR_HALF  = 2'd1,
		FACTOR_THIRD = 2'd2,
		FACTOR_ALT   = 2'd3
	} factor_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0]  RST_FACE_AXIS   = AXIS_X;
	localparam logic [1:0]  RST_FACTOR_MODE = FACTOR_THIRD;
	localparam logic [15:0] RST_MIN_MAG     = 16'd0;

endpackage

// File: rtl/surface_tension_face_tensor_unit.sv
// ----------------------------------------------------------------------------
// surface_tension_face_tensor_unit
// Face normal from four corner gradients and one row of the surface tension
// tensor f*|n|*I - n n^T/|n|, saturated to Q7.16.
// ----------------------------------------------------------------------------
// A face is taken in every cycle that start is high (busy stays low), and its
// row appears with done after passing through these registers in order:
// three stages of sum and squares, one square root stage per result bit (22),
// a multiply stage, a rounding stage, one divide stage per quotient bit (24)
// and the output register. Results cannot be held off; every done beat must
// be taken. Write face_axis, factor_mode and min_magnitude only while no face
// is in flight.
module surface_tension_face_tensor_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [stft_pkg::IN_W-1:0] c0_nx,
	input  logic signed [stft_pkg::IN_W-1:0] c0_ny,
	input  logic signed [stft_pkg::IN_W-1:0] c0_nz,
	input  logic signed [stft_pkg::IN_W-1:0] c1_nx,
	input  logic signed [stft_pkg::IN_W-1:0] c1_ny,
	input  logic signed [stft_pkg::IN_W-1:0] c1_nz,
	input  logic signed [stft_pkg::IN_W-1:0] c2_nx,
	input  logic signed [stft_pkg::IN_W-1:0] c2_ny,
	input  logic signed [stft_pkg::IN_W-1:0] c2_nz,
	input  logic signed [stft_pkg::IN_W-1:0] c3_nx,
	input  logic signed [stft_pkg::IN_W-1:0] c3_ny,
	input  logic signed [stft_pkg::IN_W-1:0] c3_nz,
	output logic done,
	output logic signed [stft_pkg::OUT_W-1:0] row_x,
	output logic signed [stft_pkg::OUT_W-1:0] row_y,
	output logic signed [stft_pkg::OUT_W-1:0] row_z,
	output logic tiny_normal,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [stft_pkg::ADDR_W-1:0] paddr,
	input  logic [stft_pkg::DATA_W-1:0] pwdata,
	output logic [stft_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int N_W   = stft_pkg::N_W;
	localparam int SQ_W  = stft_pkg::SQ_W;
	localparam int MAG_W = stft_pkg::MAG_W;
	localparam int SQS   = stft_pkg::SQ_STEPS;
	localparam int DVS   = stft_pkg::DIV_STEPS;
	localparam int Q_W   = stft_pkg::Q_W;
	localparam int DV_W  = stft_pkg::DV_W;
	localparam int V_W   = stft_pkg::V_W;
	localparam int DG_W  = stft_pkg::DG_W;
	localparam int DP_W  = stft_pkg::DP_W;
	localparam int OUT_W = stft_pkg::OUT_W;

	// ---------------- configuration port ----------------
	logic [1:0]  face_axis_q;
	logic [1:0]  factor_mode_q;
	logic [15:0] min_mag_q;
	stft_pkg::reg_idx_t reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = stft_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_axis_q   <= stft_pkg::RST_FACE_AXIS;
			factor_mode_q <= stft_pkg::RST_FACTOR_MODE;
			min_mag_q     <= stft_pkg::RST_MIN_MAG;
		end else if (wr_en) begin
			unique case (reg_idx)
				stft_pkg::REG_FACE_AXIS:   face_axis_q   <= pwdata[1:0];
				stft_pkg::REG_FACTOR_MODE: factor_mode_q <= pwdata[1:0];
				stft_pkg::REG_MIN_MAG:     min_mag_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			stft_pkg::REG_FACE_AXIS:   prdata = {30'd0, face_axis_q};
			stft_pkg::REG_FACTOR_MODE: prdata = {30'd0, factor_mode_q};
			stft_pkg::REG_MIN_MAG:     prdata = {16'd0, min_mag_q};
			default:                   prdata = '0;
		endcase
	end

	logic [1:0] axis;
	assign axis = (face_axis_q == 2'd3) ? stft_pkg::AXIS_Z : face_axis_q;

	// ---------------- stage 1: face normal ----------------
	logic              v_s1;
	logic signed [N_W-1:0] n_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		n_s1[0] <= N_W'(c0_nx) + N_W'(c1_nx) + N_W'(c2_nx) + N_W'(c3_nx);
		n_s1[1] <= N_W'(c0_ny) + N_W'(c1_ny) + N_W'(c2_ny) + N_W'(c3_ny);
		n_s1[2] <= N_W'(c0_nz) + N_W'(c1_nz) + N_W'(c2_nz) + N_W'(c3_nz);
	end

	// ---------------- stage 2: squares, stage 3: sum ----------------
	logic              v_s2, v_s3;
	logic signed [N_W-1:0] n_s2 [3];
	logic signed [N_W-1:0] n_s3 [3];
	logic [SQ_W-1:0]   sq_s2 [3];
	logic [SQ_W-1:0]   sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			sq_s2[j] <= SQ_W'($signed(n_s1[j]) * $signed(n_s1[j]));
			n_s2[j]  <= n_s1[j];
			n_s3[j]  <= n_s2[j];
		end
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	// ---------------- square root: one result bit per stage ----------------
	logic              rt_v_s   [SQS+1];
	logic [SQ_W-1:0]   rt_x_s   [SQS+1];
	logic [SQ_W-1:0]   rt_res_s [SQS+1];
	logic signed [N_W-1:0] rt_n_s [SQS+1][3];

	assign rt_v_s[0]   = v_s3;
	assign rt_x_s[0]   = sum_s3;
	assign rt_res_s[0] = '0;
	assign rt_n_s[0]   = n_s3;

	for (genvar i = 0; i < SQS; i++) begin : g_root
		localparam int BP = 2 * (SQS - 1 - i);
		logic [SQ_W-1:0] rbit;
		logic [SQ_W:0]   trial;
		assign rbit  = SQ_W'(1) << BP;
		assign trial = {1'b0, rt_res_s[i]} + {1'b0, rbit};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[i+1] <= 1'b0;
			else         rt_v_s[i+1] <= rt_v_s[i];
		end

		always_ff @(posedge clk) begin
			rt_n_s[i+1] <= rt_n_s[i];
			if ({1'b0, rt_x_s[i]} >= trial) begin
				rt_x_s[i+1]   <= rt_x_s[i] - trial[SQ_W-1:0];
				rt_res_s[i+1] <= (rt_res_s[i] >> 1) + rbit;
			end else begin
				rt_x_s[i+1]   <= rt_x_s[i];
				rt_res_s[i+1] <= rt_res_s[i] >> 1;
			end
		end
	end

	logic [MAG_W-1:0] mag_root;
	assign mag_root = rt_res_s[SQS][MAG_W-1:0];

	// ---------------- products and diagonal scale ----------------
	logic              v_sp;
	logic [SQ_W-1:0]   prod_sp [3];
	logic              neg_sp  [3];
	logic [MAG_W-1:0]  mag_sp;
	logic [DP_W-1:0]   dprod_sp;
	logic              tiny_sp;
	logic [N_W-1:0]    abs_n [3];
	logic [DG_W-1:0]   mag_p1;

	always_comb begin
		for (int j = 0; j < 3; j++)
			abs_n[j] = rt_n_s[SQS][j][N_W-1] ? N_W'(-rt_n_s[SQS][j]) : rt_n_s[SQS][j];
	end
	assign mag_p1 = DG_W'(mag_root) + DG_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sp <= 1'b0;
		else         v_sp <= rt_v_s[SQS];
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			prod_sp[j] <= SQ_W'(abs_n[axis] * abs_n[j]);
			neg_sp[j]  <= rt_n_s[SQS][axis][N_W-1] ^ rt_n_s[SQS][j][N_W-1];
		end
		mag_sp   <= mag_root;
		dprod_sp <= DP_W'(mag_p1) * DP_W'(stft_pkg::RECIP3);
		tiny_sp  <= mag_root <= MAG_W'(min_mag_q);
	end

	// ---------------- rounding offset and diagonal ----------------
	logic              v_sn;
	logic [SQ_W-1:0]   num_sn [3];
	logic              neg_sn [3];
	logic [MAG_W-1:0]  mag_sn;
	logic [DG_W-1:0]   diag_sn;
	logic              tiny_sn;
	logic [DG_W-1:0]   diag_nx;

	always_comb begin
		unique case (stft_pkg::factor_t'(factor_mode_q))
			stft_pkg::FACTOR_HALF:  diag_nx = DG_W'((DG_W'(mag_sp) + DG_W'(1)) >> 1);
			stft_pkg::FACTOR_THIRD: diag_nx = DG_W'(dprod_sp >> stft_pkg::RECIP3_SHIFT);
			default:                diag_nx = DG_W'(mag_sp);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sn <= 1'b0;
		else         v_sn <= v_sp;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			num_sn[j] <= prod_sp[j] + SQ_W'(mag_sp >> 1);
			neg_sn[j] <= neg_sp[j];
		end
		mag_sn  <= mag_sp;
		diag_sn <= diag_nx;
		tiny_sn <= tiny_sp;
	end

	// ---------------- divide: one quotient bit per stage ----------------
	logic              dv_v_s    [DVS+1];
	logic [SQ_W-1:0]   dv_rem_s  [DVS+1][3];
	logic [Q_W-1:0]    dv_q_s    [DVS+1][3];
	logic              dv_neg_s  [DVS+1][3];
	logic [MAG_W-1:0]  dv_mag_s  [DVS+1];
	logic [DG_W-1:0]   dv_diag_s [DVS+1];
	logic              dv_tiny_s [DVS+1];

	assign dv_v_s[0]    = v_sn;
	assign dv_rem_s[0]  = num_sn;
	assign dv_q_s[0]    = '{default: '0};
	assign dv_neg_s[0]  = neg_sn;
	assign dv_mag_s[0]  = mag_sn;
	assign dv_diag_s[0] = diag_sn;
	assign dv_tiny_s[0] = tiny_sn;

	for (genvar i = 0; i < DVS; i++) begin : g_div
		localparam int BP = DVS - 1 - i;
		logic [DV_W-1:0] shd;
		assign shd = DV_W'(dv_mag_s[i]) << BP;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[i+1] <= 1'b0;
			else         dv_v_s[i+1] <= dv_v_s[i];
		end

		always_ff @(posedge clk) begin
			for (int j = 0; j < 3; j++) begin
				if (DV_W'(dv_rem_s[i][j]) >= shd) begin
					dv_rem_s[i+1][j] <= dv_rem_s[i][j] - shd[SQ_W-1:0];
					dv_q_s[i+1][j]   <= dv_q_s[i][j] | (Q_W'(1) << BP);
				end else begin
					dv_rem_s[i+1][j] <= dv_rem_s[i][j];
					dv_q_s[i+1][j]   <= dv_q_s[i][j];
				end
			end
			dv_neg_s[i+1]  <= dv_neg_s[i];
			dv_mag_s[i+1]  <= dv_mag_s[i];
			dv_diag_s[i+1] <= dv_diag_s[i];
			dv_tiny_s[i+1] <= dv_tiny_s[i];
		end
	end

	// ---------------- sign, diagonal, saturate ----------------
	logic signed [OUT_W-1:0] row_nx [3];

	always_comb begin
		logic signed [V_W-1:0] qv;
		logic signed [V_W-1:0] v;
		for (int j = 0; j < 3; j++) begin
			qv = V_W'(dv_q_s[DVS][j]);
			if (dv_neg_s[DVS][j]) qv = -qv;
			if (dv_tiny_s[DVS])   qv = '0;
			v = ((j == 32'(axis)) ? V_W'(dv_diag_s[DVS]) : V_W'(0)) - qv;
			if (v > V_W'(2 ** (OUT_W - 1) - 1))
				row_nx[j] = {1'b0, {(OUT_W-1){1'b1}}};
			else if (v < V_W'(-(2 ** (OUT_W - 1))))
				row_nx[j] = {1'b1, {(OUT_W-1){1'b0}}};
			else
				row_nx[j] = v[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= dv_v_s[DVS];
	end

	always_ff @(posedge clk) begin
		row_x       <= row_nx[0];
		row_y       <= row_nx[1];
		row_z       <= row_nx[2];
		tiny_normal <= dv_tiny_s[DVS];
	end

	// ---------------- assertions ----------------
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, stft_pkg::LATENCY))
		else $error("done beat without a face accepted LATENCY cycles earlier");

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		rt_v_s[SQS] |-> rt_res_s[SQS][SQ_W-1:MAG_W] == '0)
		else $error("square root result exceeds magnitude width");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[0] && !dv_tiny_s[0] |-> dv_mag_s[0] != '0)
		else $error("division entered with zero magnitude");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Face tensor row unit testbench
// Drives corner gradient faces through the unit under several register
// settings and idle patterns, predicts each tensor row and checks it.
// ----------------------------------------------------------------------------
class row_scoreboard;
	typedef struct {
		logic signed [23:0] rx, ry, rz;
		logic tiny;
	} row_t;

	row_t pending[$];
	int errors;
	int checked;

	logic [1:0]  axis;
	logic [1:0]  fmode;
	logic [15:0] thresh;

	function new();
		errors = 0;
		checked = 0;
		axis = stft_pkg::RST_FACE_AXIS;
		fmode = stft_pkg::RST_FACTOR_MODE;
		thresh = stft_pkg::RST_MIN_MAG;
	endfunction

	function void write_reg(int idx, logic [31:0] val);
		if (idx == stft_pkg::REG_FACE_AXIS) axis = val[1:0];
		else if (idx == stft_pkg::REG_FACTOR_MODE) fmode = val[1:0];
		else if (idx == stft_pkg::REG_MIN_MAG) thresh = val[15:0];
	endfunction

	static function longint unsigned root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	static function longint prod_div(longint a, longint b, longint unsigned m);
		longint unsigned ua, ub, q;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		q = (ua * ub + m / 2) / m;
		return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
	endfunction

	static function logic signed [23:0] clip(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function void note_face(logic signed [19:0] g [12]);
		longint n [3];
		longint unsigned sq, mag, k;
		longint v, diag;
		int d;
		logic tiny;
		row_t r;
		logic signed [23:0] o [3];
		for (int j = 0; j < 3; j++) n[j] = 0;
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 3; j++) n[j] += g[c*3+j];
		sq = 0;
		for (int j = 0; j < 3; j++) sq += n[j] * n[j];
		mag = root_floor(sq);
		d = (axis == 2'd3) ? 2 : axis;
		case (fmode)
			stft_pkg::FACTOR_HALF:  k = 2;
			stft_pkg::FACTOR_THIRD: k = 3;
			default:                k = 1;
		endcase
		diag = (mag + k / 2) / k;
		tiny = mag <= thresh;
		for (int j = 0; j < 3; j++) begin
			v = (j == d) ? diag : 0;
			if (!tiny) v -= prod_div(n[d], n[j], mag);
			o[j] = clip(v);
		end
		r.rx = o[0];
		r.ry = o[1];
		r.rz = o[2];
		r.tiny = tiny;
		pending.push_back(r);
	endfunction

	function void check_row(logic signed [23:0] rx, ry, rz, logic tiny);
		row_t e;
		if (pending.size() == 0) begin
			$error("row with no face outstanding");
			errors++;
			return;
		end
		e = pending.pop_front();
		checked++;
		if (rx !== e.rx) begin $error("row_x exp %0d got %0d", e.rx, rx); errors++; end
		if (ry !== e.ry) begin $error("row_y exp %0d got %0d", e.ry, ry); errors++; end
		if (rz !== e.rz) begin $error("row_z exp %0d got %0d", e.rz, rz); errors++; end
		if (tiny !== e.tiny) begin
			$error("tiny_normal exp %0d got %0d", e.tiny, tiny);
			errors++;
		end
	endfunction
endclass

module testbench;

	logic clk, arst_n, start, busy, done, tiny_normal;
	logic psel, penable, pwrite, pready;
	logic [stft_pkg::ADDR_W-1:0] paddr;
	logic [stft_pkg::DATA_W-1:0] pwdata, prdata;
	logic signed [stft_pkg::IN_W-1:0] g [12];
	logic signed [stft_pkg::OUT_W-1:0] row_x, row_y, row_z;

	row_scoreboard sb;
	int idle_pct;
	int n_faces;

	surface_tension_face_tensor_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.c0_nx(g[0]), .c0_ny(g[1]), .c0_nz(g[2]),
		.c1_nx(g[3]), .c1_ny(g[4]), .c1_nz(g[5]),
		.c2_nx(g[6]), .c2_ny(g[7]), .c2_nz(g[8]),
		.c3_nx(g[9]), .c3_ny(g[10]), .c3_nz(g[11]),
		.done(done), .row_x(row_x), .row_y(row_y), .row_z(row_z),
		.tiny_normal(tiny_normal),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("testbench: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_row(row_x, row_y, row_z, tiny_normal);
	end

	task automatic reg_write(int idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= stft_pkg::ADDR_W'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	// drain results, then keep start low so no face is in flight
	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (stft_pkg::LATENCY + 4) @(posedge clk);
	endtask

	// start stays high after the beat so faces can follow back to back
	task automatic send_face(logic signed [stft_pkg::IN_W-1:0] v [12]);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		for (int i = 0; i < 12; i++) g[i] <= v[i];
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_face(v);
		n_faces++;
	endtask

	function automatic logic signed [stft_pkg::IN_W-1:0] rnd_comp(int shape);
		case (shape)
			0: return stft_pkg::IN_W'($urandom);
			1: return stft_pkg::IN_W'($signed($urandom_range(0, 255)) - 128);
			2: return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
			default: return stft_pkg::IN_W'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	task automatic random_faces(int count);
		logic signed [stft_pkg::IN_W-1:0] v [12];
		int shape;
		for (int n = 0; n < count; n++) begin
			shape = $urandom_range(3);
			for (int i = 0; i < 12; i++) v[i] = rnd_comp(shape);
			// occasionally a pure axis normal or a cancelling pair
			if ($urandom_range(9) == 0)
				for (int i = 0; i < 12; i++) if (i % 3 != 0) v[i] = 0;
			if ($urandom_range(9) == 0)
				for (int i = 6; i < 12; i++) v[i] = -v[i-6];
			send_face(v);
		end
	endtask

	initial begin
		logic signed [stft_pkg::IN_W-1:0] v [12];
		int pcts [4];
		sb = new();
		arst_n = 0;
		start = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		idle_pct = 0;
		n_faces = 0;
		for (int i = 0; i < 12; i++) g[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero normal, full-scale corners, single axes, reset settings
		for (int i = 0; i < 12; i++) v[i] = 0;
		send_face(v);
		for (int i = 0; i < 12; i++) v[i] = 20'sh7FFFF;
		send_face(v);
		for (int i = 0; i < 12; i++) v[i] = 20'sh80000;
		send_face(v);
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i < 12; i++) v[i] = (i % 3 == a) ? 20'sh7FFFF : 0;
			send_face(v);
			for (int i = 0; i < 12; i++) v[i] = (i % 3 == a) ? 20'sh80000 : 20'sh00001;
			send_face(v);
		end
		for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 20'sh55555 : 20'shAAAAA;
		send_face(v);
		drain();
		// every axis code, every factor code, threshold extremes
		for (int a = 0; a < 4; a++) begin
			reg_write(stft_pkg::REG_FACE_AXIS, a);
			reg_write(stft_pkg::REG_FACTOR_MODE, 3 - a);
			reg_write(stft_pkg::REG_MIN_MAG, (a == 3) ? 16'hFFFF : a * 3);
			for (int i = 0; i < 12; i++)
				v[i] = (i < 3) ? stft_pkg::IN_W'(2 * (i + 1)) : 0;
			send_face(v);
			for (int i = 0; i < 12; i++) v[i] = stft_pkg::IN_W'($urandom);
			send_face(v);
			drain();
		end
		reg_write(stft_pkg::REG_NONE, 32'hFFFFFFFF);

		pcts[0] = 0; pcts[1] = 68; pcts[2] = 0; pcts[3] = 29;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			reg_write(stft_pkg::REG_FACE_AXIS, $urandom_range(3));
			reg_write(stft_pkg::REG_FACTOR_MODE, $urandom_range(3));
			reg_write(stft_pkg::REG_MIN_MAG, ph == 7 ? 16'hFFFF : (ph % 2 ? $urandom_range(65535)
				: $urandom_range(40)));
			idle_pct = pcts[ph % 4];
			random_faces(60);
			// sender holds off until the pipe is empty
			if (ph == 2) begin
				start <= 0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			random_faces(6);
		end
		drain();

		$display("covered %0d faces, %0d rows checked, all axis and factor codes",
			n_faces, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

// File: surface_tension_face_tensor_unit.f
rtl/stft_pkg.sv
rtl/surface_tension_face_tensor_unit.sv
verif/testbench.sv
